[design/utld_pkg.sv]
package utld_pkg;

	localparam int unsigned EPOCH_YEAR_DEF = 1970;

	localparam int unsigned TS_W   = 32;
	localparam int unsigned OFF_W  = 5;
	localparam int unsigned YEAR_W = 12;
	localparam int unsigned MON_W  = 4;
	localparam int unsigned DAY_W  = 5;
	localparam int unsigned HOUR_W = 5;
	localparam int unsigned MIN_W  = 6;
	localparam int unsigned SEC_W  = 6;

	localparam int unsigned S_TDATA_W = 40;
	localparam int unsigned M_TDATA_W = 40;

	// shared reciprocal divider
	localparam logic [25:0] DAY_RECIP    = 26'd50903317;  // 2^35 / 675, rounded up
	localparam logic [9:0]  DAY_DIV_HI   = 10'd675;       // 86400 >> 7
	localparam logic [15:0] DIV60_RECIP  = 16'd34953;     // 2^19 / 15, rounded up
	localparam logic [16:0] SECS_PER_MIN = 17'd60;
	localparam int unsigned CNT_W = 2;
	localparam logic [CNT_W-1:0] DAY_STEPS = 2'd2;
	localparam logic [CNT_W-1:0] SEC_STEPS = 2'd2;
	localparam logic [CNT_W-1:0] MIN_STEPS = 2'd2;

	// divider phase codes
	localparam logic [1:0] DIVP_DAY = 2'd0;
	localparam logic [1:0] DIVP_SEC = 2'd1;
	localparam logic [1:0] DIVP_MIN = 2'd2;

	localparam logic [6:0] HOURS_PER_DAY = 7'd24;
	localparam logic [MON_W-1:0] MONTHS_PER_YEAR = 4'd12;

	typedef struct packed {
		logic       ld;
		logic       div_step;
		logic [1:0] div_phase;
		logic       year_step;
		logic       month_step;
		logic       adjust;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic div_last;
		logic year_fit;
		logic month_fit;
	} sts_t;

	typedef struct packed {
		logic [SEC_W-1:0]  second;
		logic [MIN_W-1:0]  minute;
		logic [HOUR_W-1:0] hour;
		logic [DAY_W-1:0]  day_of_month;
		logic [MON_W-1:0]  month;
		logic [YEAR_W-1:0] year;
	} out_t;

endpackage

[design/utld_ctrl.sv]
module utld_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	output logic            m_tvalid,
	input  logic            m_tready,
	input  utld_pkg::sts_t  sts,
	output utld_pkg::cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DDAY  = 3'd1;
	localparam logic [2:0] ST_DSEC  = 3'd2;
	localparam logic [2:0] ST_DMIN  = 3'd3;
	localparam logic [2:0] ST_YEAR  = 3'd4;
	localparam logic [2:0] ST_MONTH = 3'd5;
	localparam logic [2:0] ST_ADJ   = 3'd6;
	localparam logic [2:0] ST_DONE  = 3'd7;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.div_phase  = utld_pkg::DIVP_DAY;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.ld  = 1'b1;
					state_d = ST_DDAY;
				end
			end
			ST_DDAY: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = ST_DSEC;
			end
			ST_DSEC: begin
				cmd.div_step  = 1'b1;
				cmd.div_phase = utld_pkg::DIVP_SEC;
				if (sts.div_last) state_d = ST_DMIN;
			end
			ST_DMIN: begin
				cmd.div_step  = 1'b1;
				cmd.div_phase = utld_pkg::DIVP_MIN;
				if (sts.div_last) state_d = ST_YEAR;
			end
			ST_YEAR: begin
				cmd.year_step = 1'b1;
				if (sts.year_fit) state_d = ST_MONTH;
			end
			ST_MONTH: begin
				cmd.month_step = 1'b1;
				if (sts.month_fit) state_d = ST_ADJ;
			end
			ST_ADJ: begin
				cmd.adjust = 1'b1;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

endmodule

[design/utld_dp.sv]
module utld_dp #(
	parameter int unsigned EPOCH_YEAR = utld_pkg::EPOCH_YEAR_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  utld_pkg::cmd_t                cmd,
	input  logic [utld_pkg::TS_W-1:0]     unix_seconds,
	input  logic [utld_pkg::OFF_W-1:0]    utc_offset_hours,
	output utld_pkg::sts_t                sts,
	output utld_pkg::out_t                res
);

	localparam logic [utld_pkg::YEAR_W-1:0] YEAR_INIT = utld_pkg::YEAR_W'(EPOCH_YEAR);
	localparam logic [1:0] C4_INIT   = 2'(EPOCH_YEAR % 4);
	localparam logic [6:0] C100_INIT = 7'(EPOCH_YEAR % 100);
	localparam logic [8:0] C400_INIT = 9'(EPOCH_YEAR % 400);

	function automatic logic [4:0] mdays(input logic [3:0] m, input logic leap);
		logic [4:0] d;
		case (m)
			4'd2:                      d = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
			default:                   d = 5'd31;
		endcase
		return d;
	endfunction

	// divider: multiply by the reciprocal, then restore the remainder
	logic [31:0]                    dvd_q;
	logic [15:0]                    qt_q;
	logic [utld_pkg::CNT_W-1:0]     cnt_q;
	logic                           by_day;
	logic [24:0]                    mul_a;
	logic [25:0]                    mul_b;
	logic [50:0]                    prod;
	logic [24:0]                    day_back;
	logic [9:0]                     day_rem;
	logic [16:0]                    min_back;
	logic [5:0]                     min_rem;

	// calendar working registers
	logic [15:0]                        days_q;
	logic [utld_pkg::YEAR_W-1:0]        year_q;
	logic [utld_pkg::MON_W-1:0]         month_q;
	logic [utld_pkg::HOUR_W-1:0]        hour_q;
	logic [utld_pkg::MIN_W-1:0]         minute_q;
	logic [utld_pkg::SEC_W-1:0]         second_q;
	logic [utld_pkg::OFF_W-1:0]         off_q;
	logic [1:0]                         c4_q;
	logic [6:0]                         c100_q;
	logic [8:0]                         c400_q;
	logic [utld_pkg::DAY_W-1:0]         day_q;

	logic                               leap;
	logic [8:0]                         ylen;
	logic [4:0]                         mlen;
	logic [utld_pkg::MON_W-1:0]         prev_m;
	logic [4:0]                         prev_len;
	logic [4:0]                         day0;
	logic signed [6:0]                  hsum;

	// days: (ts >> 7) / 675; minutes and hours: (x >> 2) / 15
	assign by_day   = (cmd.div_phase == utld_pkg::DIVP_DAY);
	assign mul_a    = by_day ? dvd_q[31:7] : {10'd0, dvd_q[16:2]};
	assign mul_b    = by_day ? utld_pkg::DAY_RECIP : {10'd0, utld_pkg::DIV60_RECIP};
	assign prod     = {26'd0, mul_a} * {25'd0, mul_b};
	assign day_back = {9'd0, qt_q} * {15'd0, utld_pkg::DAY_DIV_HI};
	assign day_rem  = 10'(dvd_q[31:7] - day_back);
	assign min_back = {6'd0, qt_q[10:0]} * utld_pkg::SECS_PER_MIN;
	assign min_rem  = 6'(dvd_q[16:0] - min_back);

	assign leap = (c400_q == 9'd0) || ((c4_q == 2'd0) && (c100_q != 7'd0));
	assign ylen = leap ? 9'd366 : 9'd365;
	assign mlen = mdays(month_q, leap);
	assign prev_m   = (month_q == 4'd1) ? utld_pkg::MONTHS_PER_YEAR : (month_q - 4'd1);
	assign prev_len = mdays(prev_m, leap);
	assign day0 = days_q[4:0] + 5'd1;
	assign hsum = $signed({2'b00, hour_q}) + $signed({{2{off_q[4]}}, off_q});

	assign sts.div_last  = (cnt_q == utld_pkg::CNT_W'(1));
	assign sts.year_fit  = (days_q < {7'd0, ylen});
	assign sts.month_fit = (days_q < {11'd0, mlen}) || (month_q >= utld_pkg::MONTHS_PER_YEAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.ld) begin
			cnt_q <= utld_pkg::DAY_STEPS;
		end else if (cmd.div_step) begin
			if (sts.div_last) begin
				case (cmd.div_phase)
					utld_pkg::DIVP_DAY: cnt_q <= utld_pkg::SEC_STEPS;
					utld_pkg::DIVP_SEC: cnt_q <= utld_pkg::MIN_STEPS;
					default:            cnt_q <= '0;
				endcase
			end else begin
				cnt_q <= cnt_q - utld_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld) begin
			dvd_q   <= unix_seconds;
			off_q   <= utc_offset_hours;
			year_q  <= YEAR_INIT;
			month_q <= 4'd1;
			c4_q    <= C4_INIT;
			c100_q  <= C100_INIT;
			c400_q  <= C400_INIT;
		end else if (cmd.div_step) begin
			if (sts.div_last) begin
				case (cmd.div_phase)
					utld_pkg::DIVP_DAY: begin
						days_q <= qt_q;
						dvd_q  <= {15'd0, day_rem, dvd_q[6:0]};
					end
					utld_pkg::DIVP_SEC: begin
						second_q <= min_rem;
						dvd_q    <= {21'd0, qt_q[10:0]};
					end
					default: begin
						minute_q <= min_rem;
						hour_q   <= qt_q[4:0];
					end
				endcase
			end else begin
				qt_q <= by_day ? prod[50:35] : {5'd0, prod[29:19]};
			end
		end else if (cmd.year_step && !sts.year_fit) begin
			days_q <= days_q - {7'd0, ylen};
			year_q <= year_q + 12'd1;
			c4_q   <= c4_q + 2'd1;
			c100_q <= (c100_q == 7'd99) ? 7'd0 : (c100_q + 7'd1);
			c400_q <= (c400_q == 9'd399) ? 9'd0 : (c400_q + 9'd1);
		end else if (cmd.month_step && !sts.month_fit) begin
			days_q  <= days_q - {11'd0, mlen};
			month_q <= month_q + 4'd1;
		end else if (cmd.adjust) begin
			if (hsum >= $signed(utld_pkg::HOURS_PER_DAY)) begin
				hour_q <= 5'(hsum - $signed(utld_pkg::HOURS_PER_DAY));
				if (day0 >= mlen) begin
					day_q <= 5'd1;
					if (month_q >= utld_pkg::MONTHS_PER_YEAR) begin
						month_q <= 4'd1;
						year_q  <= year_q + 12'd1;
					end else begin
						month_q <= month_q + 4'd1;
					end
				end else begin
					day_q <= day0 + 5'd1;
				end
			end else if (hsum[6]) begin
				hour_q <= 5'(hsum + $signed(utld_pkg::HOURS_PER_DAY));
				if (day0 == 5'd1) begin
					month_q <= prev_m;
					day_q   <= prev_len;
					if (month_q == 4'd1) year_q <= year_q - 12'd1;
				end else begin
					day_q <= day0 - 5'd1;
				end
			end else begin
				hour_q <= hsum[4:0];
				day_q  <= day0;
			end
		end
	end

	// output register, loaded once the previous result has left
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res.year         <= year_q;
			res.month        <= month_q;
			res.day_of_month <= day_q;
			res.hour         <= hour_q;
			res.minute       <= minute_q;
			res.second       <= second_q;
		end
	end

endmodule

[design/unix_time_to_local_datetime.sv]
// Converts a 32-bit Unix timestamp plus a whole-hour UTC offset into the local
// Gregorian date and time. One item is worked on at a time; s_tready is high
// only while the block is idle. After acceptance the divisions run first; then
// the whole years since EPOCH_YEAR (at most about 136) are peeled off the day
// count one per cycle, then the months (at most 11) one per cycle. The three
// divisions by fixed constants (days, then minutes, then hours) are each a
// multiply by a reciprocal followed by restoring the remainder. The offset is
// then applied, and the result goes to the output register once it is free.
// The result sits in an output register, so the next item is accepted while a
// finished result still waits for m_tready. Offsets of -16..15 are all applied;
// the date moves by at most one day either way, and the year wraps modulo 4096.
module unix_time_to_local_datetime #(
	parameter int unsigned EPOCH_YEAR = utld_pkg::EPOCH_YEAR_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [31:0] unix_seconds, [36:32] utc_offset_hours, [39:37] zero
	input  logic [utld_pkg::S_TDATA_W-1:0]    s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [11:0] year, [15:12] month, [20:16] day_of_month, [25:21] hour,
	// [31:26] minute, [37:32] second, [39:38] zero
	output logic [utld_pkg::M_TDATA_W-1:0]    m_tdata
);

	utld_pkg::cmd_t cmd;
	utld_pkg::sts_t sts;
	utld_pkg::out_t res;

	// sequencer: divide, peel years, peel months, apply offset, hand off
	utld_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// divider, calendar registers and output register
	utld_dp #(
		.EPOCH_YEAR (EPOCH_YEAR)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.unix_seconds     (s_tdata[31:0]),
		.utc_offset_hours (s_tdata[36:32]),
		.sts              (sts),
		.res              (res)
	);

	// pack the result fields from the lowest bit up
	assign m_tdata = {2'b00, res.second, res.minute, res.hour, res.day_of_month,
	                  res.month, res.year};

	// one item in flight: an accepted item blocks the next one
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while an item is still in work");

	// a delivered month is always a real month
	a_month: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res.month != 4'd0) && (res.month <= utld_pkg::MONTHS_PER_YEAR))
		else $error("month out of range");

	// a delivered day is never zero
	a_day: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res.day_of_month != 5'd0))
		else $error("day of month is zero");

	// the offset adjustment always lands inside the day
	a_hour: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res.hour < 5'd24))
		else $error("hour out of range");

endmodule

[tb/unix_time_to_local_datetime_tb.sv]
`timescale 1ns / 1ps

module unix_time_to_local_datetime_tb;

	// One input item: timestamp in seconds plus the signed hour offset.
	typedef struct packed {
		logic        [31:0] secs;
		logic signed [4:0]  off;
	} stamp_t;

	localparam int EPOCH          = utld_pkg::EPOCH_YEAR_DEF;
	localparam int RANDOM_PER_RUN = 300;   // random items in each idling phase
	localparam int HOLD_CYCLES    = 3000;  // long receiver hold-off
	localparam int DRAIN_CYCLES   = 300;   // above the worst latency

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                              s_tvalid = 1'b0;
	logic                              s_tready;
	// [31:0] unix_seconds, [36:32] utc_offset_hours, [39:37] zero
	logic [utld_pkg::S_TDATA_W-1:0]    s_tdata  = '0;
	logic                              m_tvalid;
	logic                              m_tready = 1'b0;
	// [11:0] year, [15:12] month, [20:16] day_of_month, [25:21] hour,
	// [31:26] minute, [37:32] second, [39:38] zero
	logic [utld_pkg::M_TDATA_W-1:0]    m_tdata;

	stamp_t          pending_stamps[$];   // items waiting to be offered
	utld_pkg::out_t  expected_dates[$];   // predicted results, oldest first

	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	logic hold_go        = 1'b0;
	logic hold_off       = 1'b0;
	int   error_count    = 0;
	int   results_seen   = 0;

	unix_time_to_local_datetime uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Gregorian leap rule: every 400th year, or every 4th that is not a century.
	function automatic bit leap_year(int y);
		return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
	endfunction

	function automatic int days_in_month(int m, int y);
		case (m)
			2:            return leap_year(y) ? 29 : 28;
			4, 6, 9, 11:  return 30;
			default:      return 31;
		endcase
	endfunction

	// Local calendar date and time of day for one item.
	function automatic utld_pkg::out_t predict_datetime(stamp_t st);
		longint days;
		int     rem;
		int     hr;
		int     mi;
		int     se;
		int     yr;
		int     mo;
		int     dy;
		int     ylen;
		utld_pkg::out_t r;
		days = longint'(st.secs) / 86400;
		rem  = int'(longint'(st.secs) % 86400);
		hr   = rem / 3600;
		mi   = (rem % 3600) / 60;
		se   = rem % 60;
		yr   = EPOCH;
		mo   = 1;
		// peel off whole years, then whole months
		forever begin
			ylen = leap_year(yr) ? 366 : 365;
			if (days < ylen)
				break;
			days -= ylen;
			yr++;
		end
		while (mo < 12 && days >= days_in_month(mo, yr)) begin
			days -= days_in_month(mo, yr);
			mo++;
		end
		dy = int'(days) + 1;
		// apply the zone offset; the date moves by at most one day
		hr += int'(st.off);
		if (hr >= 24) begin
			hr -= 24;
			if (dy >= days_in_month(mo, yr)) begin
				dy = 1;
				mo++;
				if (mo > 12) begin
					mo = 1;
					yr++;
				end
			end else begin
				dy++;
			end
		end else if (hr < 0) begin
			hr += 24;
			if (dy == 1) begin
				if (mo == 1) begin
					mo = 12;
					yr--;
				end else begin
					mo--;
				end
				dy = days_in_month(mo, yr);
			end else begin
				dy--;
			end
		end
		r.year         = yr[11:0];
		r.month        = mo[3:0];
		r.day_of_month = dy[4:0];
		r.hour         = hr[4:0];
		r.minute       = mi[5:0];
		r.second       = se[5:0];
		return r;
	endfunction

	// Seconds since the epoch for a UTC date and time (years from the epoch on).
	function automatic logic [31:0] stamp_at(int y, int m, int d, int h, int mi, int s);
		longint days;
		longint total;
		days = d - 1;
		for (int k = EPOCH; k < y; k++)
			days += leap_year(k) ? 366 : 365;
		for (int k = 1; k < m; k++)
			days += days_in_month(k, y);
		total = days * 86400 + h * 3600 + mi * 60 + s;
		return total[31:0];
	endfunction

	task automatic report_mismatch(string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic add_stamp(logic [31:0] secs, int off);
		stamp_t st;
		st.secs = secs;
		st.off  = off[4:0];
		pending_stamps.push_back(st);
	endtask

	// Random item: mostly plain timestamps, many near midnight and near month
	// ends so the offset crosses days, and some offsets outside the zone range.
	task automatic add_random_stamp();
		int          kind;
		int          off;
		int          y;
		int          m;
		longint      base;
		longint      dlt;
		logic [31:0] secs;
		kind = $urandom_range(0, 9);
		if ($urandom_range(0, 99) < 85)
			off = int'($urandom_range(0, 26)) - 12;
		else
			off = int'($urandom_range(0, 31)) - 16;
		dlt = $urandom_range(0, 16 * 3600);
		case (kind)
			4, 5, 6: begin
				base = longint'($urandom_range(0, 49710)) * 86400;
				base = $urandom_range(0, 1) ? base + dlt : base - dlt;
				secs = base[31:0];
			end
			7, 8: begin
				y = $urandom_range(EPOCH, 2105);
				m = ($urandom_range(0, 2) == 0) ? 3 : $urandom_range(1, 12);
				base = longint'(stamp_at(y, m, 1, 0, 0, 0));
				base = $urandom_range(0, 1) ? base + dlt : base - dlt;
				secs = base[31:0];
			end
			9: begin
				secs = $urandom;
				off  = ($urandom_range(0, 4) == 4) ? 15 : -16 + int'($urandom_range(0, 3));
			end
			default: secs = $urandom;
		endcase
		add_stamp(secs, off);
	endtask

	// Driver: offer the head of the pending queue; hold valid and data until
	// the item is taken, then pop it and record its predicted result.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_dates.push_back(predict_datetime(pending_stamps[0]));
				pending_stamps.pop_front();
			end
			if (!(s_tvalid && !s_tready)) begin
				if (pending_stamps.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= {3'b000, pending_stamps[0].off, pending_stamps[0].secs};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each taken result against the oldest prediction, field
	// by field, and drive the receiver's ready with random stalls.
	always @(posedge clk or negedge arst_n) begin : date_monitor
		utld_pkg::out_t got;
		utld_pkg::out_t want;
		int             got_f[6];
		int             want_f[6];
		string          field_names[6];
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[37:0];
				if (expected_dates.size() == 0) begin
					report_mismatch($sformatf("result %h with no item outstanding", m_tdata));
				end else begin
					want = expected_dates.pop_front();
					field_names = '{"year", "month", "day_of_month", "hour", "minute", "second"};
					got_f  = '{got.year, got.month, got.day_of_month,
						got.hour, got.minute, got.second};
					want_f = '{want.year, want.month, want.day_of_month,
						want.hour, want.minute, want.second};
					for (int k = 0; k < 6; k++)
						if (got_f[k] != want_f[k])
							report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
								results_seen, field_names[k], got_f[k], want_f[k]));
				end
				results_seen++;
			end
			if (hold_off)
				m_tready <= 1'b0;
			else
				m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Long receiver hold-off: the sender keeps offering, so the block fills
	// its output register, takes one more item and then stalls its input.
	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Hard limit on run time.
	initial begin
		#15_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed items: field extremes, midnight crossings both ways,
		// month and year ends, leap and non-leap February, the day before
		// the epoch and offsets outside the zone range.
		add_stamp(32'd0, 0);
		add_stamp(32'd0, -1);                        // Dec 31 of the year before
		add_stamp(32'd0, -16);
		add_stamp(32'd3599, -12);
		add_stamp(32'hFFFF_FFFF, 0);
		add_stamp(32'hFFFF_FFFF, 15);
		add_stamp(32'hFFFF_FFFF, -16);
		add_stamp(32'h7FFF_FFFF, 14);
		add_stamp(32'd86399, 1);
		add_stamp(stamp_at(2000, 2, 28, 23, 59, 59), 1);   // into leap day
		add_stamp(stamp_at(2100, 2, 28, 23, 30, 0), 1);    // century, no leap day
		add_stamp(stamp_at(2024, 2, 28, 22, 0, 0), 2);
		add_stamp(stamp_at(2024, 3, 1, 0, 30, 0), -1);     // back to Feb 29
		add_stamp(stamp_at(2023, 3, 1, 0, 30, 0), -1);     // back to Feb 28
		add_stamp(stamp_at(1999, 12, 31, 23, 0, 0), 14);   // into the new year
		add_stamp(stamp_at(2000, 1, 1, 0, 0, 0), -12);     // back to the old year
		add_stamp(stamp_at(2001, 4, 30, 23, 30, 0), 1);
		add_stamp(stamp_at(2001, 5, 1, 0, 10, 0), -1);
		add_stamp(stamp_at(2105, 12, 31, 10, 0, 0), 15);
		add_stamp(stamp_at(2038, 1, 19, 3, 14, 7), -13);
		add_stamp(stamp_at(1988, 7, 15, 12, 0, 0), -15);
		add_stamp(stamp_at(2015, 6, 30, 23, 59, 59), 13);

		// Random phases: no idling (with the long hold-off), sender idle,
		// receiver stalling, both.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_go = 1'b1; end
				1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
				default: begin send_idle_pct = 15; recv_stall_pct = 15; end
			endcase
			repeat (RANDOM_PER_RUN) add_random_stamp();
			while (pending_stamps.size() != 0 || s_tvalid)
				@(negedge clk);
		end

		// Drain: wait for every predicted result, then wait longer than the worst
		// latency so that any stray result is caught.
		while (expected_dates.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (expected_dates.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_dates.size()));

		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
